FILE: hw/rtl/sorted_greedy_budget_select_top_macros.svh
// ------------------------------------------------------------------------
// sorted_greedy_budget_select_top_macros.svh
// assertion macros used by the port checker sgbs_port_props
// ------------------------------------------------------------------------
`ifndef SORTED_GREEDY_BUDGET_SELECT_TOP_MACROS_SVH
`define SORTED_GREEDY_BUDGET_SELECT_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define SGBS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgbs assertion failed");

// next-cycle implication, disabled in reset
`define SGBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgbs assertion failed");

`endif

FILE: hw/rtl/sgbs_pkg.sv
// ------------------------------------------------------------------------
// sgbs_pkg
// shared widths, types and defaults of the greedy budget selector
// ------------------------------------------------------------------------
package sgbs_pkg;

  localparam int VAL_W         = 16;
  localparam int BUD_W         = 31;
  localparam int MAX_ITEMS_DEF = 64;

  // controller states
  typedef enum logic {
    ST_LOAD,
    ST_SCAN
  } state_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic shift;
    logic clr;
  } cell_cmd_t;

  // what the head cell shows to the controller
  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] val;
  } head_t;

endpackage

FILE: hw/rtl/sorted_greedy_budget_select_top.sv
// ------------------------------------------------------------------------
// sorted_greedy_budget_select_top
// smallest-first greedy subset selection under a budget
// ------------------------------------------------------------------------
// Usage: write the budget through cfg_we/cfg_wdata while the block is idle.
// Candidates transfer on item_value at each edge with start high and busy
// low, one per cycle, into a chain of MAX_ITEMS cells that keeps them in
// ascending order by insertion. Candidates beyond MAX_ITEMS are dropped.
// The candidate with last_item high also starts the scan and raises busy.
// During the scan the chain shifts one value per cycle into the head cell,
// where the budget compare and subtract sit; the scan ends when the chain
// is empty or the budget reaches zero. Each pick appears on result_valid
// for one cycle, in ascending order, one pick behind the compare; the
// final result carries last_pick and is shown in the first cycle with
// busy low. A run with no pick gives one result with none_picked high.
// Reset empties the chain and clears the budget register and the state.
// The receiver cannot stall; results are never held back.
// ------------------------------------------------------------------------
module sorted_greedy_budget_select_top
  import sgbs_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [BUD_W-1:0] cfg_wdata,
  input  logic             start,
  output logic             busy,
  input  logic [VAL_W-1:0] item_value,
  input  logic             last_item,
  output logic             result_valid,
  output logic [VAL_W-1:0] picked_value,
  output logic             last_pick,
  output logic             none_picked
);

  cell_cmd_t        cmd;
  head_t            head;
  logic             c_vld [MAX_ITEMS];
  logic             c_gt  [MAX_ITEMS];
  logic [VAL_W-1:0] c_val [MAX_ITEMS];

  assign head.vld = c_vld[0];
  assign head.val = c_val[0];

  // sequencer
  sgbs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .last_item    (last_item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .full         (c_vld[MAX_ITEMS-1]),
    .head         (head),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid),
    .picked_value (picked_value),
    .last_pick    (last_pick),
    .none_picked  (none_picked)
  );

  // chain of sorting cells, head at index 0
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic             p_vld, p_gt, n_vld;
    logic [VAL_W-1:0] p_val, n_val;

    if (i == 0) begin : g_first
      assign p_vld = 1'b1;
      assign p_gt  = 1'b0;
      assign p_val = '0;
    end else begin : g_mid
      assign p_vld = c_vld[i-1];
      assign p_gt  = c_gt[i-1];
      assign p_val = c_val[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign n_vld = 1'b0;
      assign n_val = '0;
    end else begin : g_body
      assign n_vld = c_vld[i+1];
      assign n_val = c_val[i+1];
    end

    sgbs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .new_val  (item_value),
      .prev_vld (p_vld),
      .prev_gt  (p_gt),
      .prev_val (p_val),
      .next_vld (n_vld),
      .next_val (n_val),
      .vld      (c_vld[i]),
      .gt       (c_gt[i]),
      .val      (c_val[i])
    );
  end

endmodule

FILE: hw/rtl/sgbs_cell.sv
// ------------------------------------------------------------------------
// sgbs_cell
// one slot of the sorted chain: insert in place, shift toward the head
// ------------------------------------------------------------------------
module sgbs_cell
  import sgbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_cmd_t        cmd,
  input  logic [VAL_W-1:0] new_val,
  input  logic             prev_vld,
  input  logic             prev_gt,
  input  logic [VAL_W-1:0] prev_val,
  input  logic             next_vld,
  input  logic [VAL_W-1:0] next_val,
  output logic             vld,
  output logic             gt,
  output logic [VAL_W-1:0] val
);

  logic [VAL_W-1:0] ins_val;

  // held value is above the incoming one, so this slot moves up
  assign gt      = vld && (val > new_val);
  assign ins_val = prev_gt ? prev_val : new_val;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      vld <= 1'b0;
    end else if (cmd.shift) begin
      vld <= next_vld;
    end else if (cmd.ins && !vld && prev_vld) begin
      vld <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      val <= next_val;
    end else if (cmd.ins && (gt || (!vld && prev_vld))) begin
      val <= ins_val;
    end
  end

endmodule

FILE: hw/rtl/sgbs_ctrl.sv
// ------------------------------------------------------------------------
// sgbs_ctrl
// load/scan sequencer, budget tracking and result register
// ------------------------------------------------------------------------
module sgbs_ctrl
  import sgbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             last_item,
  input  logic             cfg_we,
  input  logic [BUD_W-1:0] cfg_wdata,
  input  logic             full,
  input  head_t            head,
  output cell_cmd_t        cmd,
  output logic             busy,
  output logic             result_valid,
  output logic [VAL_W-1:0] picked_value,
  output logic             last_pick,
  output logic             none_picked
);

  state_t           state, state_next;
  logic [BUD_W-1:0] target_sum;
  logic [BUD_W-1:0] budget;
  logic             pend_vld;
  logic [VAL_W-1:0] pend_val;
  logic [BUD_W-1:0] head_ext;
  logic             accept;
  logic             run_go;
  logic             scan_end;
  logic             pick;

  assign head_ext = {{(BUD_W-VAL_W){1'b0}}, head.val};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (run_go)   state_next = ST_SCAN;
      ST_SCAN: if (scan_end) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  // outputs and cell commands
  always_comb begin
    busy      = (state == ST_SCAN);
    accept    = start && !busy;
    run_go    = accept && last_item;
    scan_end  = busy && (!head.vld || (budget == '0));
    pick      = busy && !scan_end && (head_ext <= budget);
    cmd.ins   = accept && !full;
    cmd.shift = busy && !scan_end;
    cmd.clr   = scan_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // budget register, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg_we) begin
      target_sum <= cfg_wdata;
    end
  end

  // remaining budget
  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= '0;
    end else if (run_go) begin
      budget <= target_sum;
    end else if (pick) begin
      budget <= budget - head_ext;
    end
  end

  // one pick held back until it is known whether it is the last
  always_ff @(posedge clk) begin
    if (rst || run_go) begin
      pend_vld <= 1'b0;
    end else if (pick) begin
      pend_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pick) begin
      pend_val <= head.val;
    end
  end

  // result transfer register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (pick && pend_vld) || scan_end;
    end
  end

  always_ff @(posedge clk) begin
    picked_value <= (scan_end && !pend_vld) ? '0 : pend_val;
    last_pick    <= scan_end;
    none_picked  <= scan_end && !pend_vld;
  end

endmodule

FILE: hw/rtl/sgbs_checker.sv
// ------------------------------------------------------------------------
// sgbs_port_props
// port-level checks of the greedy budget selector
// ------------------------------------------------------------------------
`include "sorted_greedy_budget_select_top_macros.svh"

module sgbs_port_props
  import sgbs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             last_item,
  input logic             result_valid,
  input logic [VAL_W-1:0] picked_value,
  input logic             last_pick,
  input logic             none_picked
);

  // an empty run reports a zero value and closes the run
  `SGBS_ASSERT_SAME(a_none_closes, result_valid && none_picked, last_pick && (picked_value == '0))

  // the closing result shows up once the scan has finished
  `SGBS_ASSERT_SAME(a_last_idle, result_valid && last_pick, !busy)

  // an intermediate pick means the scan is still running
  `SGBS_ASSERT_SAME(a_mid_busy, result_valid && !last_pick, busy)

  // the final candidate starts the scan
  `SGBS_ASSERT_NEXT(a_last_starts, start && !busy && last_item, busy)

endmodule

bind sorted_greedy_budget_select_top sgbs_port_props u_sgbs_checker (.*);

FILE: sim/sgbs_checker.sv
// ------------------------------------------------------------------------
// sgbs_checker
// watches the budget selector ports, predicts the picks, compares them
// ------------------------------------------------------------------------
// Keeps its own sorted copy of the candidates of the current set and its
// own copy of the budget register. When the final candidate transfers, the
// smallest-first greedy scan is run here and the expected picks are
// queued. Every result transfer is matched against the oldest queued pick
// field by field. The mismatch count and the number of picks still owed
// are handed back to the testbench top.
// ------------------------------------------------------------------------
`timescale 1ns / 100ps

module sgbs_checker
  import sgbs_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [BUD_W-1:0] cfg_wdata,
  input  logic             start,
  input  logic             busy,
  input  logic [VAL_W-1:0] item_value,
  input  logic             last_item,
  input  logic             result_valid,
  input  logic [VAL_W-1:0] picked_value,
  input  logic             last_pick,
  input  logic             none_picked,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             is_last;
    logic             is_none;
  } pick_t;

  logic [VAL_W-1:0] sorted_vals [MAX_ITEMS];
  int               held;
  logic [BUD_W-1:0] budget_cfg;
  logic [BUD_W-1:0] budget_left;
  pick_t            expected_picks [$];
  int               mismatch_cnt = 0;

  // one line per mismatch, counted
  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, field, got, want);
    mismatch_cnt++;
  endtask

  // sample all channels at the edge, in transfer order
  always @(posedge clk) begin
    pick_t            want;
    int               pos;
    int               n_picks;
    logic [VAL_W-1:0] chosen [MAX_ITEMS];
    if (rst) begin
      held        = 0;
      budget_cfg  = '0;
      budget_left = '0;
      expected_picks.delete();
    end else begin
      // result transfer against the oldest expected pick
      if (result_valid) begin
        if (expected_picks.size() == 0) begin
          report_mismatch("unexpected result, picked_value", picked_value, -1);
        end else begin
          want = expected_picks.pop_front();
          if (picked_value !== want.value)
            report_mismatch("picked_value", picked_value, want.value);
          if (last_pick !== want.is_last)
            report_mismatch("last_pick", last_pick, want.is_last);
          if (none_picked !== want.is_none)
            report_mismatch("none_picked", none_picked, want.is_none);
        end
      end

      // budget register write
      if (cfg_we) begin
        budget_cfg = cfg_wdata;
      end

      // candidate transfer
      if (start && !busy) begin
        // insertion into the sorted copy, dropped once the set is full
        if (held < MAX_ITEMS) begin
          pos = held;
          while (pos > 0 && sorted_vals[pos-1] > item_value) begin
            sorted_vals[pos] = sorted_vals[pos-1];
            pos--;
          end
          sorted_vals[pos] = item_value;
          held++;
        end

        // final candidate: greedy scan from the smallest value up
        if (last_item) begin
          budget_left = budget_cfg;
          n_picks     = 0;
          for (int i = 0; i < held; i++) begin
            if (budget_left == '0) break;
            if (sorted_vals[i] <= budget_left) begin
              chosen[n_picks] = sorted_vals[i];
              budget_left     = budget_left - sorted_vals[i];
              n_picks++;
            end
          end
          if (n_picks == 0) begin
            want.value   = '0;
            want.is_last = 1'b1;
            want.is_none = 1'b1;
            expected_picks.insert(expected_picks.size(), want);
          end else begin
            for (int k = 0; k < n_picks; k++) begin
              want.value   = chosen[k];
              want.is_last = (k == n_picks - 1);
              want.is_none = 1'b0;
              expected_picks.insert(expected_picks.size(), want);
            end
          end
          held = 0;
        end
      end
    end
    errors  <= mismatch_cnt;
    pending <= expected_picks.size();
  end

endmodule

FILE: sim/tb_sorted_greedy_budget_select_top.sv
// ------------------------------------------------------------------------
// tb_sorted_greedy_budget_select_top
// stimulus and verdict for the greedy budget selector
// ------------------------------------------------------------------------
// Sends candidate sets in bursts with random gaps and changes the budget
// between phases once every expected pick has come out. A directed part
// covers the reset budget, the largest budget, zero candidates, a budget
// that runs out, sets where nothing fits and candidates in falling order.
// The random part mixes budget scales, value ranges and set sizes up to
// and past the capacity of the chain. Checking lives in sgbs_checker.
// ------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sorted_greedy_budget_select_top;
  import sgbs_pkg::*;

  localparam int MAX_ITEMS     = MAX_ITEMS_DEF;
  localparam int SETTLE_CYCLES = MAX_ITEMS + 8;
  localparam int RANDOM_ITEMS  = 450;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [BUD_W-1:0] cfg_wdata = '0;
  logic             start     = 1'b0;
  logic [VAL_W-1:0] item_value = '0;
  logic             last_item = 1'b0;
  logic             busy;
  logic             result_valid;
  logic [VAL_W-1:0] picked_value;
  logic             last_pick;
  logic             none_picked;
  int               errors;
  int               pending;
  int               burst_left = 0;
  int               items_sent = 0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sorted_greedy_budget_select_top #(
    .MAX_ITEMS (MAX_ITEMS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .item_value   (item_value),
    .last_item    (last_item),
    .result_valid (result_valid),
    .picked_value (picked_value),
    .last_pick    (last_pick),
    .none_picked  (none_picked)
  );

  sgbs_checker #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .item_value   (item_value),
    .last_item    (last_item),
    .result_valid (result_valid),
    .picked_value (picked_value),
    .last_pick    (last_pick),
    .none_picked  (none_picked),
    .errors       (errors),
    .pending      (pending)
  );

  // one candidate transfer, with bursty idling in front of it
  task automatic send_candidate(input logic [VAL_W-1:0] v, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_value <= v;
    last_item  <= fin;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // stop sending until every expected pick is out and the block is quiet
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // budget register write, only called after drain
  task automatic write_budget(input logic [BUD_W-1:0] b);
    cfg_wdata <= b;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one set of random candidates in a chosen value flavor
  task automatic send_set(input int n);
    int               flavor;
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] v;
    flavor = $urandom_range(0, 4);
    base   = VAL_W'($urandom);
    for (int k = 0; k < n; k++) begin
      case (flavor)
        0: v = VAL_W'($urandom);
        1: v = VAL_W'($urandom_range(0, 15));
        2: begin
          case ($urandom_range(0, 4))
            0: v = 16'h0000;
            1: v = 16'h0001;
            2: v = 16'hFFFE;
            3: v = 16'hFFFF;
            default: v = VAL_W'($urandom);
          endcase
        end
        3: v = VAL_W'($urandom_range(0, 1023));
        default: v = base - VAL_W'(k * 37);
      endcase
      send_candidate(v, k == n - 1);
    end
  endtask

  // watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int n_sets;
    int size_roll;
    int scale;
    int n;
    logic [BUD_W-1:0] budget;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset budget is zero
    send_candidate(16'd5, 1'b1);
    drain();

    // largest budget takes everything, extremes and zeros
    write_budget(31'h7FFF_FFFF);
    send_candidate(16'hFFFF, 1'b0);
    send_candidate(16'h0000, 1'b0);
    send_candidate(16'h0001, 1'b0);
    send_candidate(16'hFFFF, 1'b1);
    drain();

    // zero candidates picked, budget runs out exactly
    write_budget(31'd10);
    send_candidate(16'd3, 1'b0);
    send_candidate(16'd0, 1'b0);
    send_candidate(16'd20, 1'b0);
    send_candidate(16'd7, 1'b0);
    send_candidate(16'd0, 1'b1);
    drain();

    // nothing fits
    write_budget(31'd2);
    send_candidate(16'd5, 1'b0);
    send_candidate(16'd9, 1'b1);
    drain();

    // zero budget with a zero candidate
    write_budget(31'd0);
    send_candidate(16'd0, 1'b1);
    drain();

    // exact single fit, then falling order with a skipped value
    write_budget(31'd100);
    send_candidate(16'd100, 1'b1);
    send_candidate(16'd60, 1'b0);
    send_candidate(16'd50, 1'b0);
    send_candidate(16'd40, 1'b1);
    drain();

    // random phases: new budget, a few sets, then drain
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      scale = $urandom_range(0, 9);
      case (scale)
        0:       budget = '0;
        1:       budget = 31'h7FFF_FFFF;
        2:       budget = BUD_W'($urandom_range(0, 255));
        3, 4:    budget = BUD_W'($urandom_range(0, 1 << 17));
        5, 6, 7: budget = BUD_W'($urandom_range(0, 1 << 21));
        default: budget = BUD_W'($urandom);
      endcase
      write_budget(budget);
      n_sets = $urandom_range(1, 4);
      for (int s = 0; s < n_sets; s++) begin
        size_roll = $urandom_range(0, 99);
        if (size_roll < 75)      n = $urandom_range(1, 8);
        else if (size_roll < 93) n = $urandom_range(9, 32);
        else if (size_roll < 98) n = $urandom_range(33, MAX_ITEMS);
        else                     n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
        send_set(n);
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
